>>> hw/rtl/sst_pkg.sv
package sst_pkg;

    localparam logic [1:0] MODE_DEFINE = 2'd0;
    localparam logic [1:0] MODE_LOOKUP = 2'd1;
    localparam logic [1:0] MODE_OPEN   = 2'd2;
    localparam logic [1:0] MODE_CLOSE  = 2'd3;

    localparam logic [1:0] ST_OK        = 2'd0;
    localparam logic [1:0] ST_FULL      = 2'd1;
    localparam logic [1:0] ST_UNDERFLOW = 2'd2;
    localparam logic [1:0] ST_OVERFLOW  = 2'd3;

    localparam int          CHAR_SLOTS = 11;
    localparam int          FREED_W    = 22;
    localparam logic [21:0] FREED_MAX  = 22'h3FFFFF;
    localparam logic [7:0]  SCOPE_MAX  = 8'd255;

    typedef struct packed {
        logic [1:0]         mode;
        logic [63:0]        name_head;
        logic [23:0]        name_tail;
        logic signed [15:0] frame_offset;
        logic               is_lvalue;
        logic [15:0]        object_size;
    } t_in;

    typedef struct packed {
        logic [1:0]         status;
        logic               found;
        logic signed [15:0] offset_out;
        logic               lvalue_out;
        logic [21:0]        freed_bytes;
    } t_out;

    // search token walking down the cell row
    typedef struct packed {
        logic               active;
        logic               found;
        logic signed [15:0] offset;
        logic               lvalue;
        logic               first_hit;
        logic [21:0]        freed;
    } t_tok;

endpackage

>>> hw/rtl/sst_cell.sv
module sst_cell #(
    parameter int IW  = 7,
    parameter int NW  = 88,
    parameter int IDX = 0
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_wr,
    input  logic [NW-1:0]      i_wr_name,
    input  logic signed [15:0] i_wr_offset,
    input  logic               i_wr_lvalue,
    input  logic [15:0]        i_wr_size,
    input  logic [7:0]         i_wr_scope,
    input  logic [IW-1:0]      i_fill,
    input  logic [NW-1:0]      i_key_name,
    input  logic [7:0]         i_key_scope,
    input  sst_pkg::t_tok      i_tok,
    input  logic [IW-1:0]      i_first,
    output sst_pkg::t_tok      o_tok,
    output logic [IW-1:0]      o_first
);

    logic [NW-1:0]      r_name;
    logic signed [15:0] r_offset;
    logic               r_lvalue;
    logic [15:0]        r_size;
    logic [7:0]         r_scope;
    sst_pkg::t_tok      r_tok;
    sst_pkg::t_tok      n_tok;
    logic [IW-1:0]      r_first;
    logic [IW-1:0]      n_first;
    logic               live;
    logic               scope_hit;
    logic [22:0]        sum;

    assign live      = IW'(IDX) < i_fill;
    assign scope_hit = live && (r_scope == i_key_scope);
    assign sum       = {1'b0, i_tok.freed} + {7'd0, r_size};

    always_comb begin
        n_tok   = i_tok;
        n_first = i_first;
        if (live && !i_tok.found && (r_name == i_key_name)) begin
            n_tok.found  = 1'b1;
            n_tok.offset = r_offset;
            n_tok.lvalue = r_lvalue;
        end
        if (scope_hit && !i_tok.first_hit) begin
            n_tok.first_hit = 1'b1;
            n_first         = IW'(IDX);
        end
        if (live && (i_tok.first_hit || scope_hit)) begin
            n_tok.freed = sum[22] ? sst_pkg::FREED_MAX : sum[21:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_wr) begin
            r_name   <= i_wr_name;
            r_offset <= i_wr_offset;
            r_lvalue <= i_wr_lvalue;
            r_size   <= i_wr_size;
            r_scope  <= i_wr_scope;
        end
        r_first <= n_first;
        if (!i_rst_n) begin
            r_tok <= '0;
        end else begin
            r_tok <= n_tok;
        end
    end

    assign o_tok   = r_tok;
    assign o_first = r_first;

endmodule

>>> hw/rtl/scoped_symbol_table.sv
// Scoped symbol table built as a row of DEPTH identical cells, one stored
// entry per cell. Define and open scope go from the transfer straight to
// the finish state; look up and close scope launch a token that walks the
// row one cell per clock and finish once it has left the last cell,
// whatever the fill level. One item is in work at a time and the input
// stalls until its result sits in the output register. Names are cut at
// their first zero character and at NAME_BYTES-1 characters before they
// are stored or compared.
module scoped_symbol_table #(
    parameter int DEPTH      = 64,
    parameter int NAME_BYTES = 12
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_in_valid,
    output logic          o_in_stall,
    input  sst_pkg::t_in  i_in_data,
    output logic          o_out_valid,
    input  logic          i_out_stall,
    output sst_pkg::t_out o_out_data
);

    localparam int IW = $clog2(DEPTH + 1);
    localparam int NW = 8 * (NAME_BYTES - 1);

    typedef enum logic [2:0] {
        S_IDLE = 3'b001,
        S_SCAN = 3'b010,
        S_FIN  = 3'b100
    } t_state;

    t_state          r_state, n_state;
    logic [IW-1:0]   r_fill, n_fill;
    logic [7:0]      r_scope, n_scope;
    logic [1:0]      r_mode;
    logic [NW-1:0]   r_key;
    logic            r_launch;
    sst_pkg::t_out   r_res, n_res;
    logic            r_ovalid;
    sst_pkg::t_out   r_odata;
    logic            accept;
    logic            wr;
    logic [NW-1:0]   canon;
    sst_pkg::t_tok   tok [0:DEPTH];
    logic [IW-1:0]   first [0:DEPTH];

    // name canonicalization: zero every character after the terminator and from index NAME_BYTES-1 on
    always_comb begin
        logic [87:0] raw;
        logic [87:0] cut;
        logic        ended;
        raw   = {i_in_data.name_tail, i_in_data.name_head};
        cut   = '0;
        ended = 1'b0;
        for (int i = 0; i < sst_pkg::CHAR_SLOTS; i++) begin
            if ((i >= NAME_BYTES - 1) || (raw[8*i +: 8] == 8'd0)) ended = 1'b1;
            if (!ended) cut[8*i +: 8] = raw[8*i +: 8];
        end
        canon = cut[NW-1:0];
    end

    assign accept     = i_in_valid && (r_state == S_IDLE);
    assign o_in_stall = (r_state != S_IDLE);
    // define lands in the cell at the current fill position, unless the table is full
    assign wr = accept && (i_in_data.mode == sst_pkg::MODE_DEFINE)
                && (r_fill != IW'(DEPTH));

    // token entering the row: nothing found yet, miss lvalue is one
    always_comb begin
        tok[0]        = '0;
        tok[0].active = r_launch;
        tok[0].lvalue = 1'b1;
        first[0]      = '0;
    end

    for (genvar g = 0; g < DEPTH; g++) begin : g_cell
        sst_cell #(
            .IW  (IW),
            .NW  (NW),
            .IDX (g)
        ) u_cell (
            .i_clk       (i_clk),
            .i_rst_n     (i_rst_n),
            .i_wr        (wr && (r_fill == IW'(g))),
            .i_wr_name   (canon),
            .i_wr_offset (i_in_data.frame_offset),
            .i_wr_lvalue (i_in_data.is_lvalue),
            .i_wr_size   (i_in_data.object_size),
            .i_wr_scope  (r_scope),
            .i_fill      (r_fill),
            .i_key_name  (r_key),
            .i_key_scope (r_scope),
            .i_tok       (tok[g]),
            .i_first     (first[g]),
            .o_tok       (tok[g+1]),
            .o_first     (first[g+1])
        );
    end

    always_comb begin
        n_state = r_state;
        n_fill  = r_fill;
        n_scope = r_scope;
        n_res   = r_res;
        case (r_state)
            S_IDLE: begin
                if (accept) begin
                    n_res = '0;
                    case (i_in_data.mode)
                        sst_pkg::MODE_DEFINE: begin
                            if (r_fill == IW'(DEPTH)) n_res.status = sst_pkg::ST_FULL;
                            else n_fill = r_fill + IW'(1);
                            n_state = S_FIN;
                        end
                        sst_pkg::MODE_OPEN: begin
                            if (r_scope == sst_pkg::SCOPE_MAX) begin
                                n_res.status = sst_pkg::ST_OVERFLOW;
                            end else begin
                                n_scope = r_scope + 8'd1;
                            end
                            n_state = S_FIN;
                        end
                        default: n_state = S_SCAN;
                    endcase
                end
            end
            S_SCAN: begin
                // token has left the last cell
                if (tok[DEPTH].active) begin
                    n_res = '0;
                    if (r_mode == sst_pkg::MODE_LOOKUP) begin
                        n_res.found      = tok[DEPTH].found;
                        n_res.offset_out = tok[DEPTH].offset;
                        n_res.lvalue_out = tok[DEPTH].lvalue;
                    end else begin
                        n_res.freed_bytes = tok[DEPTH].freed;
                        if (tok[DEPTH].first_hit) n_fill = first[DEPTH];
                        if (r_scope == 8'd0) n_res.status = sst_pkg::ST_UNDERFLOW;
                        else n_scope = r_scope - 8'd1;
                    end
                    n_state = S_FIN;
                end
            end
            S_FIN: begin
                if (!r_ovalid || !i_out_stall) n_state = S_IDLE;
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        r_res <= n_res;
        if (accept) begin
            r_mode <= i_in_data.mode;
            r_key  <= canon;
        end
        if ((r_state == S_FIN) && (!r_ovalid || !i_out_stall)) r_odata <= r_res;
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_fill   <= '0;
            r_scope  <= '0;
            r_launch <= 1'b0;
            r_ovalid <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_fill   <= n_fill;
            r_scope  <= n_scope;
            r_launch <= accept && ((i_in_data.mode == sst_pkg::MODE_LOOKUP)
                                   || (i_in_data.mode == sst_pkg::MODE_CLOSE));
            if ((r_state == S_FIN) && (!r_ovalid || !i_out_stall)) r_ovalid <= 1'b1;
            else if (!i_out_stall) r_ovalid <= 1'b0;
        end
    end

    assign o_out_valid = r_ovalid;
    assign o_out_data  = r_odata;

endmodule
